### sv/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// Shared types and constants of the confidence bound score unit.
// ----------------------------------------------------------------------------
package cbs_pkg;

  // fixed-point fraction bits of log and root; the radicand carries twice as many
  localparam int unsigned FRAC_BITS   = 16;
  // play counters
  localparam int unsigned COUNT_BITS  = 16;
  // reward sum
  localparam int unsigned REWARD_BITS = 16;
  // score output
  localparam int unsigned SCORE_BITS  = 20;

  // ln 2 in q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  // saturation bound of the score magnitude
  localparam logic [SCORE_BITS-1:0] SCORE_LIMIT = 20'd400000;

  // input transaction
  typedef struct packed {
    logic signed [REWARD_BITS-1:0] reward_sum;
    logic [COUNT_BITS-1:0]         total_plays;
    logic [COUNT_BITS-1:0]         arm_plays;
  } cbs_req_t;

  // result transaction
  typedef struct packed {
    logic signed [SCORE_BITS-1:0] score_tenths;
    logic                         invalid;
  } cbs_res_t;

endpackage

### sv/confidence_bound_score_unit.sv
// ----------------------------------------------------------------------------
// confidence_bound_score_unit
// Lower confidence bound x/t - sqrt(2 ln(n) / t) of one bandit arm, in tenths.
// ----------------------------------------------------------------------------
// usage:
//   a transaction enters when start_i is high and busy_o is low; busy_o is
//   tied low, so a new transaction may enter on every clock cycle
//   each result appears on res_o for one cycle with done_o high, and
//   results keep the input order
//   throughput is one transaction per cycle, set by the fully pipelined
//   datapath: an input normalize stage, 16 squaring stages for log2, one
//   ln 2 multiply, a 37 stage restoring divider, a 19 stage square root,
//   the s*t multiply, two numerator stages, a 23 stage rounding divider
//   and an output stage
//   a zero play count gives score 0 with invalid set
//   reset clears the valid chain only; transactions in flight are dropped
//   the receiver cannot stall, so nothing in the pipeline ever holds
// ----------------------------------------------------------------------------
module confidence_bound_score_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  cbs_pkg::cbs_req_t req_i,
  output logic             done_o,
  output cbs_pkg::cbs_res_t res_o
);
  import cbs_pkg::*;

  // derived widths
  localparam int unsigned K_W    = $clog2(COUNT_BITS);
  localparam int unsigned LG_W   = K_W + FRAC_BITS;
  localparam int unsigned W_W    = LG_W + 1 + FRAC_BITS;
  localparam int unsigned RAD_W  = W_W + (W_W % 2);
  localparam int unsigned ROOT_W = RAD_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned ST_W   = ROOT_W + COUNT_BITS;
  localparam int unsigned NUM_W  = REWARD_BITS + FRAC_BITS + 2;
  localparam int unsigned MAG_W  = NUM_W + 4;
  localparam int unsigned M_W    = MAG_W + 2;
  localparam int unsigned MH_W   = M_W - FRAC_BITS - 1;

  // stage positions in the valid chain
  localparam int unsigned P_LOG  = 1;
  localparam int unsigned P_LN   = P_LOG + FRAC_BITS;
  localparam int unsigned P_DV1  = P_LN + 1;
  localparam int unsigned P_SQ   = P_DV1 + W_W;
  localparam int unsigned P_MUL  = P_SQ + ROOT_W;
  localparam int unsigned P_NA   = P_MUL + 1;
  localparam int unsigned P_NB   = P_NA + 1;
  localparam int unsigned P_DV2  = P_NB + 1;
  localparam int unsigned P_OUT  = P_DV2 + MH_W;
  localparam int unsigned LATENCY = P_OUT + 1;

  // item context carried along every stage up to the output stage
  typedef struct packed {
    logic signed [REWARD_BITS-1:0] x;
    logic [COUNT_BITS-1:0]         t;
    logic                          inv;
  } ctx_t;

  typedef struct packed {
    ctx_t                 c;
    logic [K_W-1:0]       k;
    logic [31:0]          z;
    logic [FRAC_BITS-1:0] frac;
  } log_t;

  typedef struct packed {
    ctx_t            c;
    logic [COUNT_BITS-1:0] rem;
    logic [W_W-1:0]  dq;
  } dv1_t;

  typedef struct packed {
    ctx_t              c;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

  typedef struct packed {
    ctx_t                  c;
    logic [COUNT_BITS-1:0] rem;
    logic [MH_W-1:0]       dq;
    logic                  neg;
  } dv2_t;

  // valid chain, one bit per stage
  logic [LATENCY-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start_i};
    end
  end

  assign busy_o = 1'b0;

  // input stage: leading one detect and mantissa normalize
  log_t in_d, in_q;

  always_comb begin
    logic [K_W-1:0] k;
    logic [4:0]     sh;
    k = '0;
    for (int i = 0; i < COUNT_BITS; i++) begin
      if (req_i.total_plays[i]) k = K_W'(i);
    end
    sh = 5'd31 - 5'(k);
    in_d.c.x   = req_i.reward_sum;
    in_d.c.t   = req_i.arm_plays;
    in_d.c.inv = (req_i.total_plays == '0) || (req_i.arm_plays == '0);
    in_d.k     = k;
    in_d.z     = 32'(req_i.total_plays) << sh;
    in_d.frac  = '0;
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  // log2 fraction: one mantissa squaring per stage
  log_t lg_q [FRAC_BITS+1];
  assign lg_q[0] = in_q;

  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_log
    log_t lg_d;
    always_comb begin
      logic [63:0] sq;
      logic [32:0] z1;
      sq = 64'(lg_q[g].z) * 64'(lg_q[g].z);
      z1 = sq[63:31];
      lg_d      = lg_q[g];
      lg_d.z    = z1[32] ? z1[32:1] : z1[31:0];
      lg_d.frac = {lg_q[g].frac[FRAC_BITS-2:0], z1[32]};
    end
    always_ff @(posedge clk_i) begin
      lg_q[g+1] <= lg_d;
    end
  end

  // ln: scale log2 by ln 2 and round
  ctx_t           ln_c_q;
  logic [LG_W-1:0] ln_q;
  logic [LG_W+31:0] ln_prod;

  assign ln_prod = (LG_W+32)'({lg_q[FRAC_BITS].k, lg_q[FRAC_BITS].frac}) * (LG_W+32)'(LN2_Q32)
                 + (LG_W+32)'(64'h8000_0000);

  always_ff @(posedge clk_i) begin
    ln_c_q <= lg_q[FRAC_BITS].c;
    ln_q   <= ln_prod[LG_W+31:32];
  end

  // radicand divider: (2 ln << F) / t, one quotient bit per stage
  dv1_t dv1_q [W_W+1];
  always_comb begin
    dv1_q[0].c   = ln_c_q;
    dv1_q[0].rem = '0;
    dv1_q[0].dq  = {ln_q, 1'b0, FRAC_BITS'(0)};
  end

  for (genvar g = 0; g < W_W; g++) begin : g_dv1
    dv1_t dv1_d;
    always_comb begin
      logic [COUNT_BITS:0] sh;
      sh = {dv1_q[g].rem, dv1_q[g].dq[W_W-1]};
      dv1_d    = dv1_q[g];
      dv1_d.dq = {dv1_q[g].dq[W_W-2:0], 1'b0};
      if (sh >= {1'b0, dv1_q[g].c.t}) begin
        dv1_d.rem   = COUNT_BITS'(sh - {1'b0, dv1_q[g].c.t});
        dv1_d.dq[0] = 1'b1;
      end else begin
        dv1_d.rem = COUNT_BITS'(sh);
      end
    end
    always_ff @(posedge clk_i) begin
      dv1_q[g+1] <= dv1_d;
    end
  end

  // square root: one root bit per stage
  sq_t sq_q [ROOT_W+1];
  always_comb begin
    sq_q[0].c    = dv1_q[W_W].c;
    sq_q[0].rem  = '0;
    sq_q[0].root = '0;
    sq_q[0].rad  = RAD_W'(dv1_q[W_W].dq);
  end

  for (genvar g = 0; g < ROOT_W; g++) begin : g_sq
    sq_t sq_d;
    always_comb begin
      logic [REM_W+1:0] r2;
      logic [REM_W+1:0] trial;
      r2    = {sq_q[g].rem, sq_q[g].rad[RAD_W-1 -: 2]};
      trial = (REM_W+2)'({sq_q[g].root, 2'b01});
      sq_d     = sq_q[g];
      sq_d.rad = {sq_q[g].rad[RAD_W-3:0], 2'b00};
      if (r2 >= trial) begin
        sq_d.rem  = REM_W'(r2 - trial);
        sq_d.root = {sq_q[g].root[ROOT_W-2:0], 1'b1};
      end else begin
        sq_d.rem  = REM_W'(r2);
        sq_d.root = {sq_q[g].root[ROOT_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      sq_q[g+1] <= sq_d;
    end
  end

  // root times arm plays
  ctx_t           mul_c_q;
  logic [ST_W-1:0] st_q;

  always_ff @(posedge clk_i) begin
    mul_c_q <= sq_q[ROOT_W].c;
    st_q    <= ST_W'(sq_q[ROOT_W].root) * ST_W'(sq_q[ROOT_W].c.t);
  end

  // numerator x << F - s*t, split into sign and magnitude
  ctx_t               na_c_q;
  logic               na_neg_q;
  logic [NUM_W-1:0]   na_abs_q;
  logic signed [NUM_W-1:0] num;

  assign num = $signed({{(NUM_W-REWARD_BITS-FRAC_BITS){mul_c_q.x[REWARD_BITS-1]}},
                        mul_c_q.x, FRAC_BITS'(0)}) - $signed(NUM_W'(st_q));

  always_ff @(posedge clk_i) begin
    na_c_q   <= mul_c_q;
    na_neg_q <= num[NUM_W-1];
    na_abs_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  // scale by ten and add half the divisor for rounding
  ctx_t            nb_c_q;
  logic            nb_neg_q;
  logic [MH_W-1:0] nb_mh_q;
  logic [M_W-1:0]  m_sum;

  assign m_sum = (M_W'(na_abs_q) * M_W'(20))
               + M_W'({na_c_q.t, FRAC_BITS'(0)});

  always_ff @(posedge clk_i) begin
    nb_c_q   <= na_c_q;
    nb_neg_q <= na_neg_q;
    nb_mh_q  <= m_sum[M_W-1:FRAC_BITS+1];
  end

  // rounding divider by arm plays
  dv2_t dv2_q [MH_W+1];
  always_comb begin
    dv2_q[0].c   = nb_c_q;
    dv2_q[0].rem = '0;
    dv2_q[0].dq  = nb_mh_q;
    dv2_q[0].neg = nb_neg_q;
  end

  for (genvar g = 0; g < MH_W; g++) begin : g_dv2
    dv2_t dv2_d;
    always_comb begin
      logic [COUNT_BITS:0] sh;
      sh = {dv2_q[g].rem, dv2_q[g].dq[MH_W-1]};
      dv2_d    = dv2_q[g];
      dv2_d.dq = {dv2_q[g].dq[MH_W-2:0], 1'b0};
      if (sh >= {1'b0, dv2_q[g].c.t}) begin
        dv2_d.rem   = COUNT_BITS'(sh - {1'b0, dv2_q[g].c.t});
        dv2_d.dq[0] = 1'b1;
      end else begin
        dv2_d.rem = COUNT_BITS'(sh);
      end
    end
    always_ff @(posedge clk_i) begin
      dv2_q[g+1] <= dv2_d;
    end
  end

  // output stage: saturate, apply sign, force zero on invalid
  cbs_res_t res_d, res_q;

  always_comb begin
    logic [SCORE_BITS-1:0] mag;
    if (dv2_q[MH_W].dq > MH_W'(SCORE_LIMIT)) begin
      mag = SCORE_LIMIT;
    end else begin
      mag = SCORE_BITS'(dv2_q[MH_W].dq);
    end
    res_d.invalid = dv2_q[MH_W].c.inv;
    if (dv2_q[MH_W].c.inv) begin
      res_d.score_tenths = '0;
    end else if (dv2_q[MH_W].neg) begin
      res_d.score_tenths = $signed(-mag);
    end else begin
      res_d.score_tenths = $signed(mag);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = vld_q[LATENCY-1];
  assign res_o  = res_q;

  // every accepted transaction yields its result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("result strobe missing after start");

  // a zero total play count comes out flagged
  a_zero_n: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && (req_i.total_plays == '0) |-> ##LATENCY (done_o && res_o.invalid))
    else $error("zero play count not flagged");

  // flagged results carry a zero score
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.invalid |-> (res_o.score_tenths == '0))
    else $error("invalid result with nonzero score");

  // score stays within the saturation bound
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.score_tenths <= $signed(SCORE_LIMIT))
            && (res_o.score_tenths >= -$signed(SCORE_LIMIT)))
    else $error("score beyond saturation bound");

endmodule
